FILE: src/h3df_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package h3df_pkg;

  localparam int unsigned ValW  = 62;
  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 3;
  localparam int unsigned ClsW  = 3;
  localparam int unsigned LeftW = 3;

  // Frame type codes
  localparam logic [ValW-1:0] TYPE_DATA        = ValW'(64'h0);
  localparam logic [ValW-1:0] TYPE_HEADERS     = ValW'(64'h1);
  localparam logic [ValW-1:0] TYPE_PUSH_CANCEL = ValW'(64'h3);
  localparam logic [ValW-1:0] TYPE_SETTINGS    = ValW'(64'h4);
  localparam logic [ValW-1:0] TYPE_PROMISE     = ValW'(64'h5);
  localparam logic [ValW-1:0] TYPE_GOAWAY      = ValW'(64'h7);
  localparam logic [ValW-1:0] TYPE_PUSH_LIMIT  = ValW'(64'hD);

  typedef enum logic [1:0] {
    PH_TYPE = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    BP_OPEN = 2'd0,
    BP_NEXT = 2'd1,
    BP_SKIP = 2'd2
  } body_phase_t;

  typedef enum logic [KindW-1:0] {
    EV_START = 3'd0,
    EV_BYTE  = 3'd1,
    EV_PAIR  = 3'd2,
    EV_ID    = 3'd3,
    EV_END   = 3'd4
  } event_kind_t;

  typedef enum logic [ClsW-1:0] {
    CL_DATA        = 3'd0,
    CL_HEADERS     = 3'd1,
    CL_SETTINGS    = 3'd2,
    CL_GOAWAY      = 3'd3,
    CL_PUSH_CANCEL = 3'd4,
    CL_PROMISE     = 3'd5,
    CL_PUSH_LIMIT  = 3'd6,
    CL_UNKNOWN     = 3'd7
  } frame_class_t;

  typedef struct packed {
    event_kind_t      kind;
    frame_class_t     fclass;
    logic [ValW-1:0]  type_raw;
    logic [ValW-1:0]  number;
    logic [ValW-1:0]  ident;
    logic [ByteW-1:0] pbyte;
    logic             fend;
  } evt_t;

  function automatic frame_class_t class_of(input logic [ValW-1:0] t);
    frame_class_t c;
    case (t)
      TYPE_DATA:        c = CL_DATA;
      TYPE_HEADERS:     c = CL_HEADERS;
      TYPE_SETTINGS:    c = CL_SETTINGS;
      TYPE_GOAWAY:      c = CL_GOAWAY;
      TYPE_PUSH_CANCEL: c = CL_PUSH_CANCEL;
      TYPE_PROMISE:     c = CL_PROMISE;
      TYPE_PUSH_LIMIT:  c = CL_PUSH_LIMIT;
      default:          c = CL_UNKNOWN;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: src/h3df_byte_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface h3df_byte_if import h3df_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

`default_nettype wire

FILE: src/h3df_event_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface h3df_event_if import h3df_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KindW-1:0] event_kind;
  logic [ClsW-1:0]  frame_class;
  logic [ValW-1:0]  frame_type_raw;
  logic [ValW-1:0]  number_value;
  logic [ValW-1:0]  setting_ident;
  logic [ByteW-1:0] payload_byte;
  logic             frame_end;

  modport source (
    output valid, output event_kind, output frame_class, output frame_type_raw,
    output number_value, output setting_ident, output payload_byte, output frame_end,
    input ready
  );
  modport sink (
    input valid, input event_kind, input frame_class, input frame_type_raw,
    input number_value, input setting_ident, input payload_byte, input frame_end,
    output ready
  );
endinterface

`default_nettype wire

FILE: src/h3df_core.sv
`timescale 1ns / 1ps
`default_nettype none

module h3df_core import h3df_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire logic [ByteW-1:0] data,
  output logic                  has_result,
  output evt_t                  result
);

  phase_t          phase, phase_next;
  logic [ValW-1:0] accum, accum_next;
  logic [LeftW-1:0] bytes_left, bytes_left_next;
  logic [ValW-1:0] held_type, held_type_next;
  frame_class_t    held_class, held_class_next;
  logic [ValW-1:0] length_left, length_left_next;
  logic [ValW-1:0] held_ident, held_ident_next;
  body_phase_t     body_phase, body_phase_next;

  logic [ValW-1:0]  f_accum;
  logic [LeftW-1:0] f_left;
  logic             f_done;
  logic             last;

  // Varint decoder: one byte per step, big-endian, kept to 62 bits
  always_comb begin
    if (bytes_left == '0) begin
      f_accum = {{(ValW-6){1'b0}}, data[5:0]};
      case (data[7:6])
        2'd0:    f_left = LeftW'(0);
        2'd1:    f_left = LeftW'(1);
        2'd2:    f_left = LeftW'(3);
        default: f_left = LeftW'(7);
      endcase
    end else begin
      f_accum = {accum[ValW-9:0], data};
      f_left  = bytes_left - LeftW'(1);
    end
    f_done = (f_left == '0);
  end

  assign last = (length_left == ValW'(1));

  // Parser step: next state and the event this byte causes
  always_comb begin
    phase_next       = phase;
    accum_next       = accum;
    bytes_left_next  = bytes_left;
    held_type_next   = held_type;
    held_class_next  = held_class;
    length_left_next = length_left;
    held_ident_next  = held_ident;
    body_phase_next  = body_phase;
    has_result       = 1'b0;
    result           = '0;
    result.kind      = EV_START;
    result.fclass    = held_class;
    result.type_raw  = held_type;

    case (phase)
      PH_TYPE: begin
        accum_next      = f_accum;
        bytes_left_next = f_left;
        if (f_done) begin
          held_type_next  = f_accum;
          held_class_next = class_of(f_accum);
          phase_next      = PH_LEN;
        end
      end
      PH_LEN: begin
        accum_next      = f_accum;
        bytes_left_next = f_left;
        if (f_done) begin
          length_left_next = f_accum;
          body_phase_next  = BP_OPEN;
          phase_next       = (f_accum == '0) ? PH_TYPE : PH_BODY;
          has_result       = 1'b1;
          result.kind      = EV_START;
          result.number    = f_accum;
          result.fend      = (f_accum == '0);
        end
      end
      PH_BODY: begin
        length_left_next = length_left - ValW'(1);
        case (held_class)
          CL_SETTINGS: begin
            accum_next      = f_accum;
            bytes_left_next = f_left;
            if (f_done) begin
              if (body_phase == BP_OPEN) begin
                held_ident_next = f_accum;
                body_phase_next = BP_NEXT;
              end else begin
                has_result      = 1'b1;
                result.kind     = EV_PAIR;
                result.number   = f_accum;
                result.ident    = held_ident;
                result.fend     = last;
                body_phase_next = BP_OPEN;
              end
            end
          end
          CL_GOAWAY, CL_PUSH_CANCEL, CL_PROMISE, CL_PUSH_LIMIT: begin
            if (body_phase == BP_OPEN) begin
              accum_next      = f_accum;
              bytes_left_next = f_left;
              if (f_done) begin
                has_result      = 1'b1;
                result.kind     = EV_ID;
                result.number   = f_accum;
                result.fend     = last;
                body_phase_next = (held_class == CL_PROMISE) ? BP_NEXT : BP_SKIP;
              end
            end else if (body_phase == BP_NEXT) begin
              has_result   = 1'b1;
              result.kind  = EV_BYTE;
              result.pbyte = data;
              result.fend  = last;
            end
          end
          default: begin
            has_result   = 1'b1;
            result.kind  = EV_BYTE;
            result.pbyte = data;
            result.fend  = last;
          end
        endcase
        // Close the frame; a silent last byte still reports the end
        if (last) begin
          if (!has_result) begin
            has_result  = 1'b1;
            result.kind = EV_END;
            result.fend = 1'b1;
          end
          phase_next      = PH_TYPE;
          bytes_left_next = '0;
          body_phase_next = BP_OPEN;
        end
      end
      default: begin
        phase_next = PH_TYPE;
      end
    endcase
  end

  // Advance parser state on each processed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_TYPE;
      bytes_left  <= '0;
      body_phase  <= BP_OPEN;
      accum       <= '0;
      held_type   <= '0;
      held_class  <= CL_DATA;
      length_left <= '0;
      held_ident  <= '0;
    end else if (step) begin
      phase       <= phase_next;
      bytes_left  <= bytes_left_next;
      body_phase  <= body_phase_next;
      accum       <= accum_next;
      held_type   <= held_type_next;
      held_class  <= held_class_next;
      length_left <= length_left_next;
      held_ident  <= held_ident_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/http3_frame_deframer.sv
`timescale 1ns / 1ps
`default_nettype none

// HTTP/3 frame deframer. Takes one stream byte per transaction and gives at
// most one event per byte: a frame start once the type and length varints are
// complete, then payload bytes, setting pairs, an id, or a bare frame end,
// depending on the frame type. Throughput is one byte per clock cycle while
// the event side does not stall; a byte's event passes through the input
// register, then the result register, with the parser state updated in a
// single combinational step in between. Backpressure on the event side
// stalls the byte side only once both registers are full.
module http3_frame_deframer import h3df_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  h3df_byte_if.sink      byte_stream,
  h3df_event_if.source   events
);

  logic             in_valid;
  logic [ByteW-1:0] in_byte;
  logic             out_valid;
  evt_t             out_evt;
  logic             advance;
  logic             step;
  logic             has_result;
  evt_t             result;

  assign advance           = !out_valid || events.ready;
  assign step              = in_valid && advance;
  assign byte_stream.ready = !in_valid || advance;

  // Hold the accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (byte_stream.ready) begin
      in_valid <= byte_stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_stream.ready) begin
      in_byte <= byte_stream.stream_byte;
    end
  end

  h3df_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .data       (in_byte),
    .has_result (has_result),
    .result     (result)
  );

  // Load or drain the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= has_result;
    end else if (events.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_evt <= result;
    end
  end

  assign events.valid          = out_valid;
  assign events.event_kind     = out_evt.kind;
  assign events.frame_class    = out_evt.fclass;
  assign events.frame_type_raw = out_evt.type_raw;
  assign events.number_value   = out_evt.number;
  assign events.setting_ident  = out_evt.ident;
  assign events.payload_byte   = out_evt.pbyte;
  assign events.frame_end      = out_evt.fend;

  a_start_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_evt.kind == EV_START |-> out_evt.fend == (out_evt.number == '0))
    else $error("start event frame_end disagrees with zero length");

  a_bare_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_evt.kind == EV_END |-> out_evt.fend && out_evt.number == '0)
    else $error("bare end event without frame_end");

  a_byte_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_evt.kind != EV_BYTE |-> out_evt.pbyte == '0)
    else $error("payload byte set on a non-payload event");

  a_ident_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_evt.kind != EV_PAIR |-> out_evt.ident == '0)
    else $error("setting identifier set on a non-pair event");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !in_valid && !out_valid)
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

FILE: verif/http3_frame_deframer_test.sv
`timescale 1ns / 1ps

module http3_frame_deframer_test import h3df_pkg::*; ();

  localparam int StallLimit = 1000;
  localparam int TargetBytes = 1800;
  localparam int SteadyBytes = 250;

  // Tracks the frame parse and holds the events still owed by the block
  class h3_event_ledger;
    evt_t             owed[$];
    int unsigned      errors;
    phase_t           stage;
    logic [ValW-1:0]  acc;
    logic [LeftW-1:0] to_go;
    logic [ValW-1:0]  cur_type;
    frame_class_t     cur_class;
    logic [ValW-1:0]  body_remaining;
    logic [ValW-1:0]  pending_ident;
    body_phase_t      body_step;

    function new();
      owed.delete();
      errors = 0;
      stage = PH_TYPE;
      acc = '0;
      to_go = '0;
      cur_type = '0;
      cur_class = CL_DATA;
      body_remaining = '0;
      pending_ident = '0;
      body_step = BP_OPEN;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function frame_class_t classify(logic [ValW-1:0] t);
      frame_class_t c;
      case (t)
        TYPE_DATA:        c = CL_DATA;
        TYPE_HEADERS:     c = CL_HEADERS;
        TYPE_SETTINGS:    c = CL_SETTINGS;
        TYPE_GOAWAY:      c = CL_GOAWAY;
        TYPE_PUSH_CANCEL: c = CL_PUSH_CANCEL;
        TYPE_PROMISE:     c = CL_PROMISE;
        TYPE_PUSH_LIMIT:  c = CL_PUSH_LIMIT;
        default:          c = CL_UNKNOWN;
      endcase
      return c;
    endfunction

    // Shift one byte into the varint; true once the integer is complete
    function bit feed(logic [ByteW-1:0] b);
      if (to_go == 0) begin
        acc = {56'b0, b[5:0]};
        to_go = LeftW'((1 << b[7:6]) - 1);
      end else begin
        acc = {acc[ValW-9:0], b};
        to_go = to_go - LeftW'(1);
      end
      return to_go == 0;
    endfunction

    function void owe(event_kind_t k, logic [ValW-1:0] num, logic [ValW-1:0] ident,
                      logic [ByteW-1:0] pb, logic fe);
      evt_t e;
      e.kind = k;
      e.fclass = cur_class;
      e.type_raw = cur_type;
      e.number = num;
      e.ident = ident;
      e.pbyte = pb;
      e.fend = fe;
      owed.insert(owed.size(), e);
    endfunction

    // Advance the parse by one accepted byte
    function void note_byte(logic [ByteW-1:0] b);
      bit closing;
      bit produced;
      produced = 0;
      case (stage)
        PH_TYPE: begin
          if (feed(b)) begin
            cur_type = acc;
            cur_class = classify(acc);
            stage = PH_LEN;
          end
        end
        PH_LEN: begin
          if (feed(b)) begin
            body_remaining = acc;
            body_step = BP_OPEN;
            to_go = '0;
            stage = (acc == 0) ? PH_TYPE : PH_BODY;
            owe(EV_START, acc, '0, '0, acc == 0);
          end
        end
        default: begin
          body_remaining = body_remaining - ValW'(1);
          closing = (body_remaining == 0);
          case (cur_class)
            CL_SETTINGS: begin
              if (feed(b)) begin
                if (body_step == BP_OPEN) begin
                  pending_ident = acc;
                  body_step = BP_NEXT;
                end else begin
                  owe(EV_PAIR, acc, pending_ident, '0, closing);
                  body_step = BP_OPEN;
                  produced = 1;
                end
              end
            end
            CL_GOAWAY, CL_PUSH_CANCEL, CL_PROMISE, CL_PUSH_LIMIT: begin
              if (body_step == BP_OPEN) begin
                if (feed(b)) begin
                  owe(EV_ID, acc, '0, '0, closing);
                  body_step = (cur_class == CL_PROMISE) ? BP_NEXT : BP_SKIP;
                  produced = 1;
                end
              end else if (body_step == BP_NEXT) begin
                owe(EV_BYTE, '0, '0, b, closing);
                produced = 1;
              end
            end
            default: begin
              owe(EV_BYTE, '0, '0, b, closing);
              produced = 1;
            end
          endcase
          // close the frame; a silent last byte still reports the end
          if (closing) begin
            if (!produced) owe(EV_END, '0, '0, '0, 1'b1);
            stage = PH_TYPE;
            to_go = '0;
            body_step = BP_OPEN;
          end
        end
      endcase
    endfunction

    function void check_event(evt_t got);
      evt_t want;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected event: kind=%0d class=%0d type=%h num=%h ident=%h byte=%h end=%b",
                   got.kind, got.fclass, got.type_raw, got.number, got.ident, got.pbyte,
                   got.fend);
        return;
      end
      want = owed.pop_front();
      if (got.kind !== want.kind || got.fclass !== want.fclass ||
          got.type_raw !== want.type_raw || got.number !== want.number ||
          got.ident !== want.ident || got.pbyte !== want.pbyte || got.fend !== want.fend) begin
        errors++;
        if (errors <= 10) begin
          $display("event mismatch at %0t", $realtime);
          $display("  expected kind=%0d class=%0d type=%h num=%h ident=%h byte=%h end=%b",
                   want.kind, want.fclass, want.type_raw, want.number, want.ident,
                   want.pbyte, want.fend);
          $display("  actual   kind=%0d class=%0d type=%h num=%h ident=%h byte=%h end=%b",
                   got.kind, got.fclass, got.type_raw, got.number, got.ident, got.pbyte,
                   got.fend);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  h3df_byte_if  byte_stream_if ();
  h3df_event_if events_if ();

  http3_frame_deframer u_top (
    .clk         (clk),
    .rst         (rst),
    .byte_stream (byte_stream_if),
    .events      (events_if)
  );

  always #5 clk = ~clk;

  h3_event_ledger   ledger;
  logic [ByteW-1:0] frame_stream[$];
  logic [ByteW-1:0] body_bytes[$];
  int               pause_at;
  bit               steady_tail;
  int               idle_cycles;

  function automatic int min_size(input logic [63:0] v);
    if (v < 64'd64) return 0;
    if (v < 64'd16384) return 1;
    if (v < 64'd1073741824) return 2;
    return 3;
  endfunction

  // Random value that fits a varint of the given size, with the extremes mixed in
  function automatic logic [63:0] rand_value(input int sz);
    logic [63:0] mask;
    int bits;
    bits = 6 + 8 * ((1 << sz) - 1);
    mask = (64'd1 << bits) - 1;
    case ($urandom_range(0, 7))
      0: return 64'd0;
      1: return mask;
      default: return {$urandom, $urandom} & mask;
    endcase
  endfunction

  function automatic void put_varint(input bit into_body, input logic [63:0] val,
                                     input int sz);
    logic [63:0] enc;
    int n;
    int k;
    n = 1 << sz;
    enc = val | (64'(sz) << (8 * n - 2));
    for (k = n - 1; k >= 0; k--) begin
      if (into_body) body_bytes.insert(body_bytes.size(), enc[8*k +: 8]);
      else frame_stream.insert(frame_stream.size(), enc[8*k +: 8]);
    end
  endfunction

  // Write type, length and body; stretch picks oversized varint encodings
  function automatic void emit_frame(input logic [63:0] ftype, input bit stretch);
    int tsz;
    int lsz;
    tsz = stretch ? $urandom_range(min_size(ftype), 3) : min_size(ftype);
    lsz = stretch ? $urandom_range(min_size(64'(body_bytes.size())), 3)
                  : min_size(64'(body_bytes.size()));
    put_varint(0, ftype, tsz);
    put_varint(0, 64'(body_bytes.size()), lsz);
    foreach (body_bytes[i]) frame_stream.insert(frame_stream.size(), body_bytes[i]);
    body_bytes.delete();
  endfunction

  function automatic void add_random_frame();
    logic [63:0] ftype;
    int sz;
    int k;
    case ($urandom_range(0, 15))
      0, 1:    ftype = 64'(TYPE_DATA);
      2:       ftype = 64'(TYPE_HEADERS);
      3, 4, 5: ftype = 64'(TYPE_SETTINGS);
      6:       ftype = 64'(TYPE_GOAWAY);
      7:       ftype = 64'(TYPE_PUSH_CANCEL);
      8, 9:    ftype = 64'(TYPE_PROMISE);
      10:      ftype = 64'(TYPE_PUSH_LIMIT);
      default: begin
        sz = $urandom_range(0, 3);
        ftype = rand_value(sz);
      end
    endcase
    case (ledger.classify(ftype[ValW-1:0]))
      CL_SETTINGS: begin
        repeat ($urandom_range(0, 4)) begin
          sz = $urandom_range(0, 3);
          put_varint(1, rand_value(sz), sz);
          sz = $urandom_range(0, 3);
          put_varint(1, rand_value(sz), sz);
        end
      end
      CL_GOAWAY, CL_PUSH_CANCEL, CL_PUSH_LIMIT: begin
        sz = $urandom_range(0, 3);
        put_varint(1, rand_value(sz), sz);
        repeat ($urandom_range(0, 3))
          body_bytes.insert(body_bytes.size(), 8'($urandom_range(0, 255)));
      end
      CL_PROMISE: begin
        sz = $urandom_range(0, 3);
        put_varint(1, rand_value(sz), sz);
        repeat ($urandom_range(0, 10))
          body_bytes.insert(body_bytes.size(), 8'($urandom_range(0, 255)));
      end
      default: begin
        k = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
        repeat (k) body_bytes.insert(body_bytes.size(), 8'($urandom_range(0, 255)));
      end
    endcase
    // break some bodies: cut the tail or tack on stray bytes
    if (body_bytes.size() > 0 && $urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, body_bytes.size())) void'(body_bytes.pop_back());
    end else if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3))
        body_bytes.insert(body_bytes.size(), 8'($urandom_range(0, 255)));
    end
    emit_frame(ftype, $urandom_range(0, 3) == 0);
  endfunction

  function automatic void build_stream();
    // zero-length DATA
    emit_frame(64'(TYPE_DATA), 0);
    // HEADERS with a single all-ones payload byte
    body_bytes.insert(body_bytes.size(), 8'hFF);
    emit_frame(64'(TYPE_HEADERS), 0);
    // SETTINGS pair with a two-byte value
    put_varint(1, 64'd6, 0);
    put_varint(1, 64'h80, 1);
    emit_frame(64'(TYPE_SETTINGS), 0);
    // SETTINGS whose identifier is cut off by the frame end
    put_varint(1, 64'd0, 3);
    void'(body_bytes.pop_back());
    emit_frame(64'(TYPE_SETTINGS), 0);
    // GOAWAY with the largest one-byte id
    put_varint(1, 64'd63, 0);
    emit_frame(64'(TYPE_GOAWAY), 0);
    // promised push: id then one header-block byte
    put_varint(1, 64'd0, 0);
    body_bytes.insert(body_bytes.size(), 8'hAA);
    emit_frame(64'(TYPE_PROMISE), 0);
    // push cancel whose id varint is left open
    body_bytes.insert(body_bytes.size(), 8'h41);
    emit_frame(64'(TYPE_PUSH_CANCEL), 0);
    // push id limit with a skipped last byte
    put_varint(1, 64'd5, 0);
    body_bytes.insert(body_bytes.size(), 8'h77);
    emit_frame(64'(TYPE_PUSH_LIMIT), 0);
    while (frame_stream.size() < TargetBytes) add_random_frame();
    pause_at = frame_stream.size() / 2;
  endfunction

  // Offer every byte, with idle bursts and one full drain midway
  task automatic send_stream();
    int i;
    int gap;
    for (i = 0; i < frame_stream.size(); i++) begin
      steady_tail = (i >= frame_stream.size() - SteadyBytes);
      gap = 0;
      if (!steady_tail && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 5);
      if (i == pause_at || gap > 0) begin
        byte_stream_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
        if (i == pause_at) begin
          do @(negedge clk); while (ledger.pending() != 0);
        end
      end
      byte_stream_if.valid <= 1'b1;
      byte_stream_if.stream_byte <= frame_stream[i];
      do @(posedge clk); while (!byte_stream_if.ready);
      @(negedge clk);
    end
    byte_stream_if.valid <= 1'b0;
  endtask

  // Stall the event side in bursts; no new burst starts in the steady tail
  initial begin
    int stall_left;
    stall_left = 0;
    events_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (!steady_tail && stall_left == 0 && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 5);
      if (stall_left > 0) begin
        events_if.ready <= 1'b0;
        stall_left--;
      end else begin
        events_if.ready <= 1'b1;
      end
    end
  end

  // Record each transaction on both sides; stop on a long silence
  always @(posedge clk) begin
    evt_t got;
    if (!rst) begin
      if (byte_stream_if.valid && byte_stream_if.ready)
        ledger.note_byte(byte_stream_if.stream_byte);
      if (events_if.valid && events_if.ready) begin
        got.kind = event_kind_t'(events_if.event_kind);
        got.fclass = frame_class_t'(events_if.frame_class);
        got.type_raw = events_if.frame_type_raw;
        got.number = events_if.number_value;
        got.ident = events_if.setting_ident;
        got.pbyte = events_if.payload_byte;
        got.fend = events_if.frame_end;
        ledger.check_event(got);
      end
      if ((byte_stream_if.valid && byte_stream_if.ready) ||
          (events_if.valid && events_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    ledger = new();
    steady_tail = 0;
    idle_cycles = 0;
    byte_stream_if.valid <= 1'b0;
    byte_stream_if.stream_byte <= '0;
    build_stream();
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    send_stream();
    while (ledger.pending() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: files.f
src/h3df_pkg.sv
src/h3df_byte_if.sv
src/h3df_event_if.sv
src/h3df_core.sv
src/http3_frame_deframer.sv
verif/http3_frame_deframer_test.sv
